>>> design/wavp_pkg.sv
// ----------------------------------------------------------------------------
// wavp_pkg
// Types and constants shared by the WAV PCM stream parser modules.
// ----------------------------------------------------------------------------
package wavp_pkg;

  // chunk and file ids, first byte in the top bits
  localparam logic [31:0] ID_RIFF = 32'h5249_4646;
  localparam logic [31:0] ID_WAVE = 32'h5741_5645;
  localparam logic [31:0] ID_FMT  = 32'h666D_7420;
  localparam logic [31:0] ID_DATA = 32'h6461_7461;

  // result kinds
  localparam logic [1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // error codes
  localparam logic [3:0] ERR_RIFF      = 4'd0;
  localparam logic [3:0] ERR_WAVE      = 4'd1;
  localparam logic [3:0] ERR_FORMAT    = 4'd2;
  localparam logic [3:0] ERR_FMT_SIZE  = 4'd3;
  localparam logic [3:0] ERR_ZERO_CH   = 4'd4;
  localparam logic [3:0] ERR_ZERO_RATE = 4'd5;
  localparam logic [3:0] ERR_ZERO_BYTE = 4'd6;
  localparam logic [3:0] ERR_ZERO_ALGN = 4'd7;
  localparam logic [3:0] ERR_BITS      = 4'd8;
  localparam logic [3:0] ERR_ALIGN     = 4'd9;
  localparam logic [3:0] ERR_ORDER     = 4'd10;
  localparam logic [3:0] ERR_NO_FMT    = 4'd11;
  localparam logic [3:0] ERR_NO_DATA   = 4'd12;
  localparam logic [3:0] ERR_TRUNC     = 4'd13;

  // result queue
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } wavp_in_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic signed [31:0] sample_value;
    logic [15:0]        channel_index;
    logic               frame_end;
    logic [3:0]         error_code;
    logic [15:0]        channel_count;
    logic [31:0]        rate_hz;
    logic [5:0]         sample_bits;
    logic [31:0]        frames_decoded;
    logic               run_last;
  } wavp_out_t;

  // up to two results written per byte
  typedef struct packed {
    logic      wr0;
    logic      wr1;
    wavp_out_t res0;
    wavp_out_t res1;
  } wavp_push_t;

endpackage

>>> design/wavp_oq.sv
// ----------------------------------------------------------------------------
// wavp_oq
// Result queue: takes up to two results a cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
module wavp_oq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wavp_pkg::wavp_push_t push_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wavp_pkg::wavp_out_t  out_data_o
);
  import wavp_pkg::*;

  wavp_out_t        mem_q [OQ_DEPTH];
  logic [OQ_AW-1:0] wptr_q, wptr_d;
  logic [OQ_AW-1:0] rptr_q, rptr_d;
  logic [OQ_AW:0]   cnt_q, cnt_d;
  logic [OQ_AW-1:0] wptr_nx;
  logic             pop;

  assign pop     = out_valid_o && out_ready_i;
  assign wptr_nx = wptr_q + OQ_AW'(1);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (push_i.wr0 && push_i.wr1) begin
      wptr_d = wptr_q + OQ_AW'(2);
    end else if (push_i.wr0) begin
      wptr_d = wptr_nx;
    end
    if (pop) begin
      rptr_d = rptr_q + OQ_AW'(1);
    end
    cnt_d = cnt_q + (OQ_AW+1)'(push_i.wr0) + (OQ_AW+1)'(push_i.wr1) - (OQ_AW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.wr0) begin
      mem_q[wptr_q] <= push_i.res0;
    end
    if (push_i.wr1) begin
      mem_q[wptr_nx] <= push_i.res1;
    end
  end

  // room for the two results a byte may cause
  assign room_o      = cnt_q <= (OQ_AW+1)'(OQ_DEPTH - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rptr_q];

endmodule

>>> design/wavp_parse.sv
// ----------------------------------------------------------------------------
// wavp_parse
// Byte-wise RIFF/WAVE chunk walker, fmt checker and PCM sample assembler.
// ----------------------------------------------------------------------------
module wavp_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 go_i,
  input  wavp_pkg::wavp_in_t   item_i,
  output wavp_pkg::wavp_push_t push_o
);
  import wavp_pkg::*;

  typedef enum logic [7:0] {
    PH_RIFF  = 8'b0000_0001,
    PH_RSIZE = 8'b0000_0010,
    PH_WAVE  = 8'b0000_0100,
    PH_CID   = 8'b0000_1000,
    PH_CSIZE = 8'b0001_0000,
    PH_FMT   = 8'b0010_0000,
    PH_SKIP  = 8'b0100_0000,
    PH_DATA  = 8'b1000_0000
  } wavp_phase_e;

  wavp_phase_e phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [31:0] id_q, id_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] left_q, left_d;
  logic [15:0] chans_q, chans_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] align_q, align_d;
  logic [5:0]  bits_q, bits_d;
  logic        fmt_seen_q, fmt_seen_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] samp_q, samp_d;
  logic [31:0] frames_q, frames_d;
  logic        stopped_q, stopped_d;

  logic [7:0]  b;
  logic        eof;
  logic [31:0] id_next, acc_next, samp_next, left_dec;
  logic [15:0] v16;
  logic [4:0]  pos_inc;
  logic [16:0] chan_inc;
  logic        last_ch, bits_ok, frame_start, proc;
  logic [18:0] align_calc;
  logic        samp_v, summ_v, err_v, end_v;
  logic [3:0]  err_code;
  wavp_out_t   samp_res, end_res;

  assign b           = item_i.data_byte;
  assign eof         = item_i.end_of_file;
  assign id_next     = {id_q[23:0], b};
  assign acc_next    = {b, acc_q[31:8]};
  assign samp_next   = {b, samp_q[31:8]};
  assign left_dec    = left_q - 32'd1;
  assign v16         = acc_next[31:16];
  assign pos_inc     = pos_q + 5'd1;
  assign chan_inc    = {1'b0, chan_q} + 17'd1;
  assign last_ch     = chan_inc >= {1'b0, chans_q};
  assign bits_ok     = v16 inside {16'd8, 16'd16, 16'd24, 16'd32};
  // bits is a multiple of 8 here, so channels*bits/8 is channels*bytes
  assign align_calc  = 19'(chans_q) * 19'(v16[5:3]);
  // a frame that starts with fewer bytes left than one frame is the partial tail
  assign frame_start = (chan_q == '0) && (pos_q == '0);
  assign proc        = frame_start ? (left_q >= 32'(align_q)) : 1'b1;

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    id_d       = id_q;
    acc_d      = acc_q;
    left_d     = left_q;
    chans_d    = chans_q;
    rate_d     = rate_q;
    align_d    = align_q;
    bits_d     = bits_q;
    fmt_seen_d = fmt_seen_q;
    chan_d     = chan_q;
    samp_d     = samp_q;
    frames_d   = frames_q;
    stopped_d  = stopped_q;
    samp_v     = 1'b0;
    summ_v     = 1'b0;
    err_v      = 1'b0;
    err_code   = ERR_RIFF;
    samp_res   = '0;
    end_res    = '0;

    if (go_i && !stopped_q) begin
      case (phase_q)
        PH_RIFF, PH_WAVE, PH_CID: begin
          id_d = id_next;
          if (pos_q >= 5'd3) begin
            pos_d = '0;
            if (phase_q == PH_RIFF) begin
              if (id_next != ID_RIFF) begin
                err_v    = 1'b1;
                err_code = ERR_RIFF;
              end else begin
                phase_d = PH_RSIZE;
              end
            end else if (phase_q == PH_WAVE) begin
              if (id_next != ID_WAVE) begin
                err_v    = 1'b1;
                err_code = ERR_WAVE;
              end else begin
                phase_d = PH_CID;
              end
            end else begin
              phase_d = PH_CSIZE;
            end
          end else begin
            pos_d = pos_inc;
          end
        end
        PH_RSIZE: begin
          if (pos_q >= 5'd3) begin
            pos_d   = '0;
            phase_d = PH_WAVE;
          end else begin
            pos_d = pos_inc;
          end
        end
        PH_CSIZE: begin
          acc_d = acc_next;
          if (pos_q >= 5'd3) begin
            pos_d = '0;
            if (id_q == ID_FMT) begin
              left_d  = acc_next;
              phase_d = PH_FMT;
            end else if (id_q == ID_DATA) begin
              if (!fmt_seen_q) begin
                err_v    = 1'b1;
                err_code = ERR_ORDER;
              end else begin
                left_d   = acc_next;
                chan_d   = '0;
                frames_d = '0;
                samp_d   = '0;
                phase_d  = PH_DATA;
                summ_v   = acc_next == '0;
              end
            end else begin
              // odd size: the pad byte is tracked in pos
              left_d  = acc_next;
              pos_d   = {4'd0, acc_next[0]};
              phase_d = (acc_next == '0) ? PH_CID : PH_SKIP;
            end
          end else begin
            pos_d = pos_inc;
          end
        end
        PH_FMT: begin
          acc_d = acc_next;
          pos_d = pos_inc;
          if (pos_q == 5'd1) begin
            if (v16 != 16'd1) begin
              err_v    = 1'b1;
              err_code = ERR_FORMAT;
            end else if (left_q != 32'd16) begin
              err_v    = 1'b1;
              err_code = ERR_FMT_SIZE;
            end
          end else if (pos_q == 5'd3) begin
            chans_d = v16;
            if (v16 == '0) begin
              err_v    = 1'b1;
              err_code = ERR_ZERO_CH;
            end
          end else if (pos_q == 5'd7) begin
            rate_d = acc_next;
            if (acc_next == '0) begin
              err_v    = 1'b1;
              err_code = ERR_ZERO_RATE;
            end
          end else if (pos_q == 5'd11) begin
            if (acc_next == '0) begin
              err_v    = 1'b1;
              err_code = ERR_ZERO_BYTE;
            end
          end else if (pos_q == 5'd13) begin
            align_d = v16;
            if (v16 == '0) begin
              err_v    = 1'b1;
              err_code = ERR_ZERO_ALGN;
            end
          end else if (pos_q >= 5'd15) begin
            if (!bits_ok) begin
              err_v    = 1'b1;
              err_code = ERR_BITS;
            end else if (19'(align_q) != align_calc) begin
              err_v    = 1'b1;
              err_code = ERR_ALIGN;
            end else begin
              bits_d     = v16[5:0];
              fmt_seen_d = 1'b1;
              pos_d      = '0;
              phase_d    = PH_CID;
            end
          end
        end
        PH_SKIP: begin
          if (left_q != '0) begin
            left_d = left_dec;
            if ((left_dec == '0) && (pos_q == '0)) begin
              phase_d = PH_CID;
            end
          end else begin
            pos_d   = '0;
            phase_d = PH_CID;
          end
        end
        PH_DATA: begin
          if (proc) begin
            if (pos_inc >= {2'd0, bits_q[5:3]}) begin
              samp_v                 = 1'b1;
              samp_res.result_kind   = KIND_SAMPLE;
              samp_res.sample_value  = $signed(samp_next ^ {(bits_q == 6'd8), 31'd0});
              samp_res.channel_index = chan_q;
              samp_res.frame_end     = last_ch;
              samp_d                 = '0;
              pos_d                  = '0;
              if (last_ch) begin
                chan_d   = '0;
                frames_d = frames_q + 32'd1;
              end else begin
                chan_d = chan_inc[15:0];
              end
            end else begin
              samp_d = samp_next;
              pos_d  = pos_inc;
            end
          end
          left_d = left_dec;
          summ_v = left_dec == '0;
        end
        default: begin
          stopped_d = 1'b1;
        end
      endcase

      if (summ_v) begin
        stopped_d = 1'b1;
      end

      if (!err_v && !stopped_d && eof) begin
        err_v = 1'b1;
        if ((phase_d == PH_CID) || (phase_d == PH_SKIP)) begin
          err_code = fmt_seen_d ? ERR_NO_DATA : ERR_NO_FMT;
        end else begin
          err_code = ERR_TRUNC;
        end
      end
      if (err_v) begin
        stopped_d = 1'b1;
      end
    end

    end_v            = summ_v || err_v;
    end_res.run_last = 1'b1;
    if (err_v) begin
      end_res.result_kind = KIND_ERROR;
      end_res.error_code  = err_code;
    end else begin
      end_res.result_kind    = KIND_SUMMARY;
      end_res.channel_count  = chans_q;
      end_res.rate_hz        = rate_q;
      end_res.sample_bits    = bits_q;
      end_res.frames_decoded = frames_d;
    end
    samp_res.run_last = !end_v;
  end

  assign push_o.wr0  = samp_v || end_v;
  assign push_o.wr1  = samp_v && end_v;
  assign push_o.res0 = samp_v ? samp_res : end_res;
  assign push_o.res1 = end_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_RIFF;
      pos_q      <= '0;
      id_q       <= '0;
      acc_q      <= '0;
      left_q     <= '0;
      chans_q    <= '0;
      rate_q     <= '0;
      align_q    <= '0;
      bits_q     <= '0;
      fmt_seen_q <= 1'b0;
      chan_q     <= '0;
      samp_q     <= '0;
      frames_q   <= '0;
      stopped_q  <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      id_q       <= id_d;
      acc_q      <= acc_d;
      left_q     <= left_d;
      chans_q    <= chans_d;
      rate_q     <= rate_d;
      align_q    <= align_d;
      bits_q     <= bits_d;
      fmt_seen_q <= fmt_seen_d;
      chan_q     <= chan_d;
      samp_q     <= samp_d;
      frames_q   <= frames_d;
      stopped_q  <= stopped_d;
    end
  end

endmodule

>>> design/wav_pcm_stream_parser.sv
// ----------------------------------------------------------------------------
// wav_pcm_stream_parser
// WAV file byte stream in, PCM samples, format summary or error out.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one file byte per transfer, end_of_file set on the last one.
//   out channel : results in file order; sample transfers carry a Q1.31 value
//                 with its channel and a frame-end flag, then one summary or
//                 one error closes the stream. run_last marks the last result
//                 caused by a byte.
//   path        : a byte taken into the input register is parsed when the
//                 result queue has room; its results are written to the queue.
//   throughput  : one byte per cycle while the result queue has room; the
//                 parse step from input register to queue is combinational.
//   stalls      : the four-entry result queue keeps taking bytes while the
//                 receiver stalls, until fewer than two entries are free;
//                 then in_ready_o drops once the input register is full.
//   reset       : the parser waits for the RIFF id and the queue is empty.
//                 After a summary or an error, bytes are still taken and
//                 dropped until the next reset.
// ----------------------------------------------------------------------------
module wav_pcm_stream_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wavp_pkg::wavp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wavp_pkg::wavp_out_t out_data_o
);
  import wavp_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  wavp_in_t   s1_data_q;
  logic       room;
  logic       s1_go;
  wavp_push_t push;

  assign s1_go      = s1_valid_q && room;
  assign in_ready_o = !s1_valid_q || s1_go;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
  end

  wavp_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (s1_go),
    .item_i (s1_data_q),
    .push_o (push)
  );

  wavp_oq u_oq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> design/wavp_checker.sv
// ----------------------------------------------------------------------------
// wavp_checker
// Port-level checks for the WAV PCM stream parser, bound to the top level.
// ----------------------------------------------------------------------------
module wavp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input wavp_pkg::wavp_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input wavp_pkg::wavp_out_t out_data_o
);
  import wavp_pkg::*;

  // a stalled byte stays offered unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("byte offer withdrawn or changed while stalled");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // summary and error always close the results of their byte
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.result_kind != KIND_SAMPLE) |-> out_data_o.run_last)
    else $error("closing result without run_last");

  // nothing follows a summary or an error
  a_end_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && (out_data_o.result_kind != KIND_SAMPLE)
    |=> !out_valid_o)
    else $error("result after end of stream");

endmodule

bind wav_pcm_stream_parser wavp_checker u_wavp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
